### rtl/pil_pkg.sv
package pil_pkg;

    localparam int unsigned ElemWidth = 32;
    localparam int unsigned PosWidth  = 8;

    typedef enum logic [2:0] {
        FN_INSERT    = 3'd0,
        FN_REMOVE    = 3'd1,
        FN_OVERWRITE = 3'd2,
        FN_READ      = 3'd3,
        FN_APPEND    = 3'd4,
        FN_CLEAR     = 3'd5
    } func_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // what every cell does this cycle
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_WRITE  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [PosWidth-1:0]   pos;
        logic [ElemWidth-1:0]  value;
    } cell_cmd_t;

endpackage

### rtl/pil_cell.sv
module pil_cell (
    input  logic                             aclk,
    input  logic [pil_pkg::PosWidth-1:0]     cell_index,
    input  pil_pkg::cell_cmd_t               cmd,
    input  logic [pil_pkg::ElemWidth-1:0]    left_value,
    input  logic [pil_pkg::ElemWidth-1:0]    right_value,
    output logic [pil_pkg::ElemWidth-1:0]    value
);
    import pil_pkg::*;

    logic [ElemWidth-1:0] value_reg;
    logic [ElemWidth-1:0] value_next;

    always_comb begin
        value_next = value_reg;
        unique case (cmd.op)
            OP_INSERT: begin
                // open a gap at pos, shift later elements up
                if (cell_index == cmd.pos) begin
                    value_next = cmd.value;
                end else if (cell_index > cmd.pos) begin
                    value_next = left_value;
                end
            end
            OP_REMOVE: begin
                if (cell_index >= cmd.pos) begin
                    value_next = right_value;
                end
            end
            OP_WRITE: begin
                if (cell_index == cmd.pos) begin
                    value_next = cmd.value;
                end
            end
            OP_NONE: begin
                value_next = value_reg;
            end
            default: begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

### rtl/positional_integer_list.sv
// Result: registered; it reaches m_tdata in the cycle after its request item is accepted.
// Throughput: one item per cycle unless a result stalls on m_tready; every cell of the
// element chain moves in the same cycle, so an insert or remove costs no more than a read.
// Reset: aresetn (synchronous, active low) empties the list and drops any pending
// result; element cells are not reset and are only read below the count.
module positional_integer_list #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // func[2:0], position[10:3], value[42:11], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // read_value[31:0], status[33:32], count[41:34], zero
);
    import pil_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [CW-1:0]        count_reg;
    logic [CW-1:0]        count_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [47:0]          m_tdata_reg;
    logic [47:0]          m_tdata_next;

    logic                 fire;
    logic [2:0]           fn;
    logic [PosWidth-1:0]  pos;
    logic [ElemWidth-1:0] val;
    logic [PosWidth-1:0]  count8;
    logic                 full;
    logic [ElemWidth-1:0] rd;
    status_t              status;
    cell_cmd_t            cmd;
    logic [ElemWidth-1:0] elem [CAPACITY];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;
    assign fn       = s_tdata[2:0];
    assign pos      = s_tdata[10:3];
    assign val      = s_tdata[42:11];
    assign count8   = PosWidth'(count_reg);
    assign full     = (count_reg == CW'(CAPACITY));

    always_comb begin
        cmd.op     = OP_NONE;
        cmd.pos    = pos;
        cmd.value  = val;
        status     = ST_DONE;
        rd         = '0;
        count_next = count_reg;
        if (fire) begin
            unique case (fn)
                FN_INSERT: begin
                    if (pos > count8) begin
                        status = ST_RANGE;
                    end else if (full) begin
                        status = ST_FULL;
                    end else begin
                        cmd.op     = OP_INSERT;
                        count_next = CW'(count_reg + 1'b1);
                    end
                end
                FN_REMOVE: begin
                    if (pos >= count8) begin
                        status = ST_RANGE;
                    end else begin
                        cmd.op     = OP_REMOVE;
                        count_next = CW'(count_reg - 1'b1);
                    end
                end
                FN_OVERWRITE: begin
                    if (pos >= count8) begin
                        status = ST_RANGE;
                    end else begin
                        cmd.op = OP_WRITE;
                    end
                end
                FN_READ: begin
                    if (pos >= count8) begin
                        status = ST_RANGE;
                    end else begin
                        rd = elem[pos[IW-1:0]];
                    end
                end
                FN_APPEND: begin
                    if (full) begin
                        status = ST_FULL;
                    end else begin
                        cmd.op     = OP_WRITE;
                        cmd.pos    = count8;
                        count_next = CW'(count_reg + 1'b1);
                    end
                end
                FN_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                    status = ST_DONE;
                end
            endcase
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (fire) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {6'd0, PosWidth'(count_next), status, rd};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [ElemWidth-1:0] left_value;
            logic [ElemWidth-1:0] right_value;
            if (gi == 0) begin : g_first
                assign left_value = val;
            end else begin : g_left
                assign left_value = elem[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right_value = elem[gi];
            end else begin : g_right
                assign right_value = elem[gi+1];
            end
            pil_cell u_cell (
                .aclk        (aclk),
                .cell_index  (PosWidth'(gi)),
                .cmd         (cmd),
                .left_value  (left_value),
                .right_value (right_value),
                .value       (elem[gi])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(CAPACITY))
        else $error("element count above capacity");

    a_no_overrun : assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid_reg && !m_tready))
        else $error("input taken while result stalled");

    a_clear_empties : assert property (@(posedge aclk) disable iff (!aresetn)
        fire && fn == FN_CLEAR |=> count_reg == '0)
        else $error("clear left elements behind");

    a_full_status : assert property (@(posedge aclk) disable iff (!aresetn)
        fire && status == ST_FULL |-> full && count_next == count_reg)
        else $error("full status without a full list");
`endif

endmodule
